/* rtl/core/mcfl_pkg.sv */
// ----------------------------------------------------------------------------
// mcfl_pkg
// Shared constants, types and helpers for the multichannel circular fault log.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfl_pkg;

    // Ring geometry
    localparam int FEEDERS   = 8;
    localparam int PHASES    = 4;
    localparam int DEPTH     = 15;
    localparam int CHANNELS  = FEEDERS * PHASES * 2;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int REC_WORDS = CHANNELS * DEPTH;
    localparam int REC_AW    = $clog2(REC_WORDS);

    // Field widths
    localparam int OPC_W   = 2;
    localparam int FDR_W   = 3;
    localparam int PHS_W   = 2;
    localparam int NTH_W   = 4;
    localparam int STAMP_W = 56;
    localparam int CUR_W   = 16;
    localparam int DUR_W   = 16;
    localparam int MEAS_W  = CUR_W + DUR_W + 2;
    localparam int REC_W   = STAMP_W + MEAS_W;
    localparam int CNT_W   = 4;
    localparam int TOT_W   = 32;
    localparam int POS_W   = 4;
    localparam int CHS_W   = POS_W + TOT_W;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Decoded command as it sits in the queue
    typedef struct packed {
        op_t                op;
        logic               bad;
        logic [CH_W-1:0]    ch;
        logic [NTH_W-1:0]   nth;
        logic [STAMP_W-1:0] stamp;
        logic [MEAS_W-1:0]  meas;   // {power_on, below_nominal, duration, current}
    } cmd_t;

    // Per-channel state word
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [TOT_W-1:0] total;
    } chan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REC
    } back_state_t;

    // Records held in a ring: min(total, DEPTH)
    function automatic logic [CNT_W-1:0] shown_of(input logic [TOT_W-1:0] total);
        logic [CNT_W-1:0] res;
        if (total > TOT_W'(DEPTH))
            res = CNT_W'(DEPTH);
        else
            res = total[CNT_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mcfl_ram.sv */
// ----------------------------------------------------------------------------
// mcfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfl_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(WORDS)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(WORDS)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [WORDS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mcfl_front.sv */
// ----------------------------------------------------------------------------
// mcfl_front
// Accepts input transactions, decodes channel and validity, and buffers the
// decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfl_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mcfl_pkg::OPC_W-1:0]    opcode,
    input  wire logic [mcfl_pkg::FDR_W-1:0]    feeder_sel,
    input  wire logic [mcfl_pkg::PHS_W-1:0]    phase_sel,
    input  wire logic                          permanent,
    input  wire logic [mcfl_pkg::NTH_W-1:0]    nth,
    input  wire logic [mcfl_pkg::STAMP_W-1:0]  stamp,
    input  wire logic [mcfl_pkg::CUR_W-1:0]    current_tenths,
    input  wire logic [mcfl_pkg::DUR_W-1:0]    duration_ms,
    input  wire logic                          below_nominal,
    input  wire logic                          power_on,
    // queue head toward the back end
    output logic                               q_valid,
    output mcfl_pkg::cmd_t                     q_cmd,
    input  wire logic                          q_pop
);

    mcfl_pkg::cmd_t                    dec_cmd;
    mcfl_pkg::cmd_t                    q_mem_reg [mcfl_pkg::QDEPTH];
    logic [mcfl_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [mcfl_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [mcfl_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [mcfl_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [mcfl_pkg::QCNT_W-1:0]       count_reg;
    logic [mcfl_pkg::QCNT_W-1:0]       count_next;
    logic                              push;
    logic                              bad_sel;

    // decode: channel number and range check
    always_comb
    begin
        bad_sel = ({1'b0, feeder_sel} >= (mcfl_pkg::FDR_W + 1)'(mcfl_pkg::FEEDERS)) ||
                  ({1'b0, phase_sel} >= (mcfl_pkg::PHS_W + 1)'(mcfl_pkg::PHASES));
        dec_cmd.op    = mcfl_pkg::op_t'(opcode);
        dec_cmd.bad   = bad_sel && (dec_cmd.op != mcfl_pkg::OP_CLEAR);
        dec_cmd.ch    = mcfl_pkg::CH_W'((int'(feeder_sel) * mcfl_pkg::PHASES +
                                          int'(phase_sel)) * 2 + int'(permanent));
        dec_cmd.nth   = nth;
        dec_cmd.stamp = stamp;
        dec_cmd.meas  = {power_on, below_nominal, duration_ms, current_tenths};
    end

    // queue control
    assign in_stall = (count_reg == mcfl_pkg::QCNT_W'(mcfl_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mcfl_pkg::QPTR_W'(mcfl_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + mcfl_pkg::QPTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mcfl_pkg::QPTR_W'(mcfl_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + mcfl_pkg::QPTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + mcfl_pkg::QCNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - mcfl_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

    // back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("pop from empty command queue");

    // fill level tracks pushes and pops
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + mcfl_pkg::QCNT_W'(1))
        else $error("queue count lost a push");

    // fill level never passes the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mcfl_pkg::QCNT_W'(mcfl_pkg::QDEPTH))
        else $error("command queue overfilled");

endmodule

`default_nettype wire

/* rtl/core/mcfl_back.sv */
// ----------------------------------------------------------------------------
// mcfl_back
// Executes decoded commands against the channel state and record RAMs and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfl_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // queue head
    input  wire logic                          q_valid,
    input  wire mcfl_pkg::cmd_t                q_cmd,
    output logic                               q_pop,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [mcfl_pkg::STAMP_W-1:0]       entry_stamp,
    output logic [mcfl_pkg::CUR_W-1:0]         entry_current,
    output logic [mcfl_pkg::DUR_W-1:0]         entry_duration,
    output logic                               entry_below_nominal,
    output logic                               entry_power_on,
    output logic [mcfl_pkg::CNT_W-1:0]         shown_count,
    output logic [mcfl_pkg::TOT_W-1:0]         total_faults
);

    mcfl_pkg::back_state_t            state_reg;
    mcfl_pkg::back_state_t            state_next;
    mcfl_pkg::cmd_t                   cur_reg;
    logic [mcfl_pkg::CHANNELS-1:0]    chv_reg;
    logic [mcfl_pkg::CHANNELS-1:0]    chv_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             ok_reg;
    logic                             ok_next;
    logic [mcfl_pkg::REC_W-1:0]       entry_reg;
    logic [mcfl_pkg::REC_W-1:0]       entry_next;
    logic [mcfl_pkg::CNT_W-1:0]       count_reg;
    logic [mcfl_pkg::CNT_W-1:0]       count_next;
    logic [mcfl_pkg::TOT_W-1:0]       total_reg;
    logic [mcfl_pkg::TOT_W-1:0]       total_next;

    // RAM ports
    logic [mcfl_pkg::CHS_W-1:0]       chan_rd_data;
    logic                             chan_we;
    mcfl_pkg::chan_t                  chan_wr;
    logic                             rec_we;
    logic                             rec_re;
    logic [mcfl_pkg::REC_AW-1:0]      rec_addr;
    logic [mcfl_pkg::REC_W-1:0]       rec_rd_data;

    // execute-stage datapath
    mcfl_pkg::chan_t                  chan_q;
    logic                             cur_live;
    logic [mcfl_pkg::POS_W-1:0]       pos_raw;
    logic [mcfl_pkg::POS_W-1:0]       pos;
    logic [mcfl_pkg::POS_W-1:0]       pos_inc;
    logic [mcfl_pkg::TOT_W-1:0]       total;
    logic [mcfl_pkg::TOT_W-1:0]       total_inc;
    logic [mcfl_pkg::CNT_W-1:0]       shown_cur;
    logic                             hit;
    logic [mcfl_pkg::POS_W:0]         slot_wide;
    logic [mcfl_pkg::POS_W-1:0]       slot;
    logic [mcfl_pkg::REC_AW-1:0]      base;
    logic                             do_append;
    logic                             do_read_hit;

    // channel state: write position and running total
    mcfl_ram #(
        .WIDTH (mcfl_pkg::CHS_W),
        .WORDS (mcfl_pkg::CHANNELS)
    ) u_chan_ram (
        .clk     (clk),
        .wr_en   (chan_we),
        .wr_addr (cur_reg.ch),
        .wr_data (chan_wr),
        .rd_en   (q_pop),
        .rd_addr (q_cmd.ch),
        .rd_data (chan_rd_data)
    );

    // records: {stamp, measures}
    mcfl_ram #(
        .WIDTH (mcfl_pkg::REC_W),
        .WORDS (mcfl_pkg::REC_WORDS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (rec_addr),
        .wr_data ({cur_reg.stamp, cur_reg.meas}),
        .rd_en   (rec_re),
        .rd_addr (rec_addr),
        .rd_data (rec_rd_data)
    );

    // channel word; a channel not written since reset or clear reads as zero
    always_comb
    begin
        chan_q    = mcfl_pkg::chan_t'(chan_rd_data);
        cur_live  = chv_reg[cur_reg.ch];
        pos_raw   = cur_live ? chan_q.pos : '0;
        pos       = (pos_raw >= mcfl_pkg::POS_W'(mcfl_pkg::DEPTH)) ? '0 : pos_raw;
        total     = cur_live ? chan_q.total : '0;
        total_inc = (total == mcfl_pkg::TOTAL_MAX) ? total : total + mcfl_pkg::TOT_W'(1);
        pos_inc   = (pos == mcfl_pkg::POS_W'(mcfl_pkg::DEPTH - 1)) ?
                    '0 : pos + mcfl_pkg::POS_W'(1);
        shown_cur = mcfl_pkg::shown_of(total);
        hit       = (cur_reg.nth < shown_cur);

        // slot of the nth newest record, wrapping below zero
        slot_wide = {1'b0, pos}
                  + ((cur_reg.nth < pos) ? '0 : (mcfl_pkg::POS_W + 1)'(mcfl_pkg::DEPTH))
                  - (mcfl_pkg::POS_W + 1)'(1)
                  - {1'b0, cur_reg.nth};
        slot      = slot_wide[mcfl_pkg::POS_W-1:0];

        base      = mcfl_pkg::REC_AW'(int'(cur_reg.ch) * mcfl_pkg::DEPTH);
        rec_addr  = base + mcfl_pkg::REC_AW'((cur_reg.op == mcfl_pkg::OP_APPEND) ? pos : slot);

        do_append   = (state_reg == mcfl_pkg::ST_EXEC) && !cur_reg.bad &&
                      (cur_reg.op == mcfl_pkg::OP_APPEND);
        do_read_hit = (state_reg == mcfl_pkg::ST_EXEC) && !cur_reg.bad &&
                      (cur_reg.op == mcfl_pkg::OP_READ) && hit;

        chan_we       = do_append;
        rec_we        = do_append;
        rec_re        = do_read_hit;
        chan_wr.pos   = pos_inc;
        chan_wr.total = total_inc;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcfl_pkg::ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    state_next = mcfl_pkg::ST_EXEC;
                end
            end
            mcfl_pkg::ST_EXEC:
            begin
                state_next = do_read_hit ? mcfl_pkg::ST_REC : mcfl_pkg::ST_IDLE;
            end
            mcfl_pkg::ST_REC:
            begin
                state_next = mcfl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mcfl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: pop, channel flags, result register
    always_comb
    begin
        q_pop          = 1'b0;
        chv_next       = chv_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        entry_next     = entry_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        unique case (state_reg)
            mcfl_pkg::ST_IDLE:
            begin
                q_pop = q_valid && !out_valid_reg;
            end
            mcfl_pkg::ST_EXEC:
            begin
                entry_next = '0;
                count_next = '0;
                total_next = '0;
                ok_next    = 1'b0;
                if (cur_reg.op == mcfl_pkg::OP_CLEAR)
                begin
                    chv_next = '0;
                    ok_next  = 1'b1;
                end
                else if (!cur_reg.bad)
                begin
                    case (cur_reg.op)
                        mcfl_pkg::OP_APPEND:
                        begin
                            chv_next[cur_reg.ch] = 1'b1;
                            ok_next    = 1'b1;
                            count_next = mcfl_pkg::shown_of(total_inc);
                            total_next = total_inc;
                        end
                        mcfl_pkg::OP_QUERY:
                        begin
                            ok_next    = 1'b1;
                            count_next = shown_cur;
                            total_next = total;
                        end
                        default:
                        begin
                            // read: ok and the entry follow in the next state on a hit
                            count_next = shown_cur;
                            total_next = total;
                        end
                    endcase
                end
                out_valid_next = !do_read_hit;
            end
            mcfl_pkg::ST_REC:
            begin
                ok_next        = 1'b1;
                entry_next     = rec_rd_data;
                out_valid_next = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcfl_pkg::ST_IDLE;
            chv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chv_reg       <= chv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_cmd;
        end
        ok_reg    <= ok_next;
        entry_reg <= entry_next;
        count_reg <= count_next;
        total_reg <= total_next;
    end

    assign out_valid           = out_valid_reg;
    assign ok                  = ok_reg;
    assign entry_stamp         = entry_reg[mcfl_pkg::REC_W-1 -: mcfl_pkg::STAMP_W];
    assign entry_power_on      = entry_reg[mcfl_pkg::MEAS_W-1];
    assign entry_below_nominal = entry_reg[mcfl_pkg::MEAS_W-2];
    assign entry_duration      = entry_reg[mcfl_pkg::CUR_W + mcfl_pkg::DUR_W - 1 -:
                                           mcfl_pkg::DUR_W];
    assign entry_current       = entry_reg[mcfl_pkg::CUR_W-1:0];
    assign shown_count         = count_reg;
    assign total_faults        = total_reg;

    // record fetch only follows execute
    a_rec_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mcfl_pkg::ST_REC |-> $past(state_reg) == mcfl_pkg::ST_EXEC)
        else $error("record fetch without execute");

    // back end is busy only while the result register is empty
    a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != mcfl_pkg::ST_IDLE |-> !out_valid_reg)
        else $error("command in flight while a result waits");

    // a pop always starts execution
    a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == mcfl_pkg::ST_EXEC)
        else $error("popped command not executed");

    // results are only produced by execute or record fetch
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) != mcfl_pkg::ST_IDLE)
        else $error("result appeared from idle");

endmodule

`default_nettype wire

/* rtl/core/multichannel_circular_fault_log.sv */
// ----------------------------------------------------------------------------
// multichannel_circular_fault_log
// Circular fault log with one ring per feeder, phase and kind: append, read
// nth newest, query count and total, and clear all.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  input     in    in_valid/in_stall    opcode .. power_on (one command)
//  output    out   out_valid/out_stall  ok .. total_faults (one result)
//
//  The back end reads the channel state RAM, then executes each command; a
//  read that finds a record adds a second registered read from the record
//  RAM. No command is taken while a result waits in the output register.
//  The front queue holds two commands and takes input while the back works.
//  Reset empties all rings at once through per-channel flags; no clearing pass.
//  Record RAM contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_circular_fault_log (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mcfl_pkg::OPC_W-1:0]    opcode,
    input  wire logic [mcfl_pkg::FDR_W-1:0]    feeder_sel,
    input  wire logic [mcfl_pkg::PHS_W-1:0]    phase_sel,
    input  wire logic                          permanent,
    input  wire logic [mcfl_pkg::NTH_W-1:0]    nth,
    input  wire logic [mcfl_pkg::STAMP_W-1:0]  stamp,
    input  wire logic [mcfl_pkg::CUR_W-1:0]    current_tenths,
    input  wire logic [mcfl_pkg::DUR_W-1:0]    duration_ms,
    input  wire logic                          below_nominal,
    input  wire logic                          power_on,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [mcfl_pkg::STAMP_W-1:0]       entry_stamp,
    output logic [mcfl_pkg::CUR_W-1:0]         entry_current,
    output logic [mcfl_pkg::DUR_W-1:0]         entry_duration,
    output logic                               entry_below_nominal,
    output logic                               entry_power_on,
    output logic [mcfl_pkg::CNT_W-1:0]         shown_count,
    output logic [mcfl_pkg::TOT_W-1:0]         total_faults
);

    logic            q_valid;
    logic            q_pop;
    mcfl_pkg::cmd_t  q_cmd;

    // decode and command queue
    mcfl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .feeder_sel     (feeder_sel),
        .phase_sel      (phase_sel),
        .permanent      (permanent),
        .nth            (nth),
        .stamp          (stamp),
        .current_tenths (current_tenths),
        .duration_ms    (duration_ms),
        .below_nominal  (below_nominal),
        .power_on       (power_on),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop)
    );

    // execution against the ring storage
    mcfl_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (q_valid),
        .q_cmd               (q_cmd),
        .q_pop               (q_pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .ok                  (ok),
        .entry_stamp         (entry_stamp),
        .entry_current       (entry_current),
        .entry_duration      (entry_duration),
        .entry_below_nominal (entry_below_nominal),
        .entry_power_on      (entry_power_on),
        .shown_count         (shown_count),
        .total_faults        (total_faults)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel circular fault log. A queue of
// commands (a directed opening, then phases of random traffic focused on a
// few rings per phase) feeds a valid/stall driver. Each accepted transaction
// runs through an in-bench ring model whose expected result is queued and
// matched field by field against what the monitor accepts. Both sides idle
// at random; the receiver holds off once for a long stretch to back up the
// block, and some commands wait until every result has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int PHASE_LEN    = 50;
    localparam int PHASE_COUNT  = 10;
    localparam int BURST_PHASE  = 2;
    localparam int LONG_HOLD    = 120;
    localparam int SETTLE       = 20;
    localparam int LIMIT_CYCLES = 400_000;

    // One command as queued for the driver
    typedef struct {
        mcfl_pkg::op_t                op;
        logic [mcfl_pkg::FDR_W-1:0]   feeder;
        logic [mcfl_pkg::PHS_W-1:0]   phase;
        logic                         perm;
        logic [mcfl_pkg::NTH_W-1:0]   nth;
        logic [mcfl_pkg::STAMP_W-1:0] stamp;
        logic [mcfl_pkg::CUR_W-1:0]   current;
        logic [mcfl_pkg::DUR_W-1:0]   duration;
        logic                         below;
        logic                         power;
        int                           gap;     // idle cycles after this transaction
        bit                           drain;   // hold back until all results are in
    } log_cmd_t;

    // One result, in port order
    typedef struct packed {
        logic                         ok;
        logic [mcfl_pkg::STAMP_W-1:0] stamp;
        logic [mcfl_pkg::CUR_W-1:0]   current;
        logic [mcfl_pkg::DUR_W-1:0]   duration;
        logic                         below;
        logic                         power;
        logic [mcfl_pkg::CNT_W-1:0]   count;
        logic [mcfl_pkg::TOT_W-1:0]   total;
    } log_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid       = 1'b0;
    logic                         in_stall;
    logic [mcfl_pkg::OPC_W-1:0]   opcode         = '0;
    logic [mcfl_pkg::FDR_W-1:0]   feeder_sel     = '0;
    logic [mcfl_pkg::PHS_W-1:0]   phase_sel      = '0;
    logic                         permanent      = 1'b0;
    logic [mcfl_pkg::NTH_W-1:0]   nth            = '0;
    logic [mcfl_pkg::STAMP_W-1:0] stamp          = '0;
    logic [mcfl_pkg::CUR_W-1:0]   current_tenths = '0;
    logic [mcfl_pkg::DUR_W-1:0]   duration_ms    = '0;
    logic                         below_nominal  = 1'b0;
    logic                         power_on       = 1'b0;

    logic                         out_valid;
    logic                         out_stall      = 1'b0;
    logic                         ok;
    logic [mcfl_pkg::STAMP_W-1:0] entry_stamp;
    logic [mcfl_pkg::CUR_W-1:0]   entry_current;
    logic [mcfl_pkg::DUR_W-1:0]   entry_duration;
    logic                         entry_below_nominal;
    logic                         entry_power_on;
    logic [mcfl_pkg::CNT_W-1:0]   shown_count;
    logic [mcfl_pkg::TOT_W-1:0]   total_faults;

    // Ring model state
    logic [mcfl_pkg::STAMP_W-1:0] ring_stamp [mcfl_pkg::REC_WORDS];
    logic [mcfl_pkg::MEAS_W-1:0]  ring_meas  [mcfl_pkg::REC_WORDS];
    logic [mcfl_pkg::POS_W-1:0]   ring_pos   [mcfl_pkg::CHANNELS];
    logic [mcfl_pkg::TOT_W-1:0]   ring_total [mcfl_pkg::CHANNELS];

    log_cmd_t    command_queue[$];
    log_result_t awaited_results[$];
    log_cmd_t    cur_cmd;

    int n_sent      = 0;
    int n_checked   = 0;
    int gap_left    = 0;
    int fail_count  = 0;
    int burst_at    = 0;
    int hold_left   = 0;
    int rx_cycle    = 0;
    bit rx_calm     = 1'b0;
    bit long_done   = 1'b0;

    multichannel_circular_fault_log i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (opcode),
        .feeder_sel          (feeder_sel),
        .phase_sel           (phase_sel),
        .permanent           (permanent),
        .nth                 (nth),
        .stamp               (stamp),
        .current_tenths      (current_tenths),
        .duration_ms         (duration_ms),
        .below_nominal       (below_nominal),
        .power_on            (power_on),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .ok                  (ok),
        .entry_stamp         (entry_stamp),
        .entry_current       (entry_current),
        .entry_duration      (entry_duration),
        .entry_below_nominal (entry_below_nominal),
        .entry_power_on      (entry_power_on),
        .shown_count         (shown_count),
        .total_faults        (total_faults)
    );

    always #(CLK_HALF) clk = ~clk;

    // Records held in a ring
    function automatic logic [mcfl_pkg::CNT_W-1:0] ring_fill(
        input logic [mcfl_pkg::TOT_W-1:0] total);
        return (total > mcfl_pkg::TOT_W'(mcfl_pkg::DEPTH)) ?
               mcfl_pkg::CNT_W'(mcfl_pkg::DEPTH) : total[mcfl_pkg::CNT_W-1:0];
    endfunction

    // Apply one command to the ring model and return the result it gives
    function automatic log_result_t predict_log(input log_cmd_t c);
        log_result_t                 r;
        int                          ch;
        int                          p;
        int                          slot;
        logic [mcfl_pkg::MEAS_W-1:0] m;
        r = '0;
        if (c.op == mcfl_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < mcfl_pkg::CHANNELS; i++)
            begin
                ring_pos[i]   = '0;
                ring_total[i] = '0;
            end
            r.ok = 1'b1;
            return r;
        end
        if (int'(c.feeder) >= mcfl_pkg::FEEDERS || int'(c.phase) >= mcfl_pkg::PHASES)
            return r;
        ch = (int'(c.feeder) * mcfl_pkg::PHASES + int'(c.phase)) * 2 + int'(c.perm);
        p  = int'(ring_pos[ch]);
        case (c.op)
            mcfl_pkg::OP_APPEND:
            begin
                ring_stamp[ch * mcfl_pkg::DEPTH + p] = c.stamp;
                ring_meas[ch * mcfl_pkg::DEPTH + p]  =
                    {c.power, c.below, c.duration, c.current};
                ring_pos[ch] = mcfl_pkg::POS_W'((p + 1) % mcfl_pkg::DEPTH);
                if (ring_total[ch] != mcfl_pkg::TOTAL_MAX)
                    ring_total[ch] = ring_total[ch] + mcfl_pkg::TOT_W'(1);
                r.ok = 1'b1;
            end
            mcfl_pkg::OP_READ:
            begin
                if (c.nth < ring_fill(ring_total[ch]))
                begin
                    slot       = (p + mcfl_pkg::DEPTH - 1 - int'(c.nth)) % mcfl_pkg::DEPTH;
                    m          = ring_meas[ch * mcfl_pkg::DEPTH + slot];
                    r.ok       = 1'b1;
                    r.stamp    = ring_stamp[ch * mcfl_pkg::DEPTH + slot];
                    r.current  = m[mcfl_pkg::CUR_W-1:0];
                    r.duration = m[mcfl_pkg::CUR_W +: mcfl_pkg::DUR_W];
                    r.below    = m[mcfl_pkg::CUR_W + mcfl_pkg::DUR_W];
                    r.power    = m[mcfl_pkg::CUR_W + mcfl_pkg::DUR_W + 1];
                end
            end
            default: r.ok = 1'b1;
        endcase
        r.count = ring_fill(ring_total[ch]);
        r.total = ring_total[ch];
        return r;
    endfunction

    function automatic log_cmd_t make_cmd(input mcfl_pkg::op_t op, input int feeder,
                                          input int phase, input int perm, input int age);
        log_cmd_t c;
        c.op       = op;
        c.feeder   = mcfl_pkg::FDR_W'(feeder);
        c.phase    = mcfl_pkg::PHS_W'(phase);
        c.perm     = perm[0];
        c.nth      = mcfl_pkg::NTH_W'(age);
        c.stamp    = '0;
        c.current  = '0;
        c.duration = '0;
        c.below    = 1'b0;
        c.power    = 1'b0;
        c.gap      = 0;
        c.drain    = 1'b0;
        return c;
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", n_checked, msg);
        fail_count++;
    endtask

    // Driver: present queued commands, predict each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin : sender
        int gap_n;
        int sent_n;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            n_sent   <= 0;
        end
        else
        begin
            gap_n  = gap_left;
            sent_n = n_sent;
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(predict_log(cur_cmd));
                sent_n = sent_n + 1;
                gap_n  = cur_cmd.gap;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_n > 0)
                begin
                    in_valid <= 1'b0;
                    gap_n = gap_n - 1;
                end
                else if (command_queue.size() > 0 &&
                         !(command_queue[0].drain && sent_n != n_checked))
                begin
                    cur_cmd = command_queue.pop_front();
                    in_valid       <= 1'b1;
                    opcode         <= cur_cmd.op;
                    feeder_sel     <= cur_cmd.feeder;
                    phase_sel      <= cur_cmd.phase;
                    permanent      <= cur_cmd.perm;
                    nth            <= cur_cmd.nth;
                    stamp          <= cur_cmd.stamp;
                    current_tenths <= cur_cmd.current;
                    duration_ms    <= cur_cmd.duration;
                    below_nominal  <= cur_cmd.below;
                    power_on       <= cur_cmd.power;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            gap_left <= gap_n;
            n_sent   <= sent_n;
        end
    end

    // Receiver stall: random hold-offs, calm stretches, one long hold
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int len;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            rx_cycle  <= 0;
            rx_calm   <= 1'b0;
            long_done <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 200 == 0)
                rx_calm <= ($urandom_range(0, 2) == 0);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!long_done && n_sent >= burst_at)
            begin
                out_stall <= 1'b1;
                hold_left <= LONG_HOLD - 1;
                long_done <= 1'b1;
            end
            else if (rx_calm)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                len = idle_len();
                out_stall <= (len > 0);
                if (len > 0)
                    hold_left <= len - 1;
            end
        end
    end

    // Monitor: match each accepted result against the oldest expectation
    always @(posedge clk)
    begin : monitor
        log_result_t seen;
        log_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {ok, entry_stamp, entry_current, entry_duration, entry_below_nominal,
                    entry_power_on, shown_count, total_faults};
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result arrived with none awaited");
            end
            else
            begin
                want = awaited_results.pop_front();
                if (seen.ok !== want.ok)
                    report_mismatch($sformatf("ok got %0h want %0h", seen.ok, want.ok));
                if (seen.stamp !== want.stamp)
                    report_mismatch($sformatf("entry_stamp got %0h want %0h",
                                              seen.stamp, want.stamp));
                if (seen.current !== want.current)
                    report_mismatch($sformatf("entry_current got %0h want %0h",
                                              seen.current, want.current));
                if (seen.duration !== want.duration)
                    report_mismatch($sformatf("entry_duration got %0h want %0h",
                                              seen.duration, want.duration));
                if (seen.below !== want.below)
                    report_mismatch($sformatf("entry_below_nominal got %0h want %0h",
                                              seen.below, want.below));
                if (seen.power !== want.power)
                    report_mismatch($sformatf("entry_power_on got %0h want %0h",
                                              seen.power, want.power));
                if (seen.count !== want.count)
                    report_mismatch($sformatf("shown_count got %0d want %0d",
                                              seen.count, want.count));
                if (seen.total !== want.total)
                    report_mismatch($sformatf("total_faults got %0d want %0d",
                                              seen.total, want.total));
            end
            n_checked <= n_checked + 1;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        log_cmd_t c;
        int       gen_total [mcfl_pkg::CHANNELS];
        int       hot0;
        int       hot1;
        int       ch;
        int       pick;
        int       fill;
        bit       quiet;

        for (int i = 0; i < mcfl_pkg::CHANNELS; i++)
        begin
            ring_pos[i]   = '0;
            ring_total[i] = '0;
            gen_total[i]  = 0;
        end

        // Directed: empty ring, field extremes, too-old read, wraparound, clear
        command_queue.push_back(make_cmd(mcfl_pkg::OP_QUERY, 0, 0, 0, 0));
        command_queue.push_back(make_cmd(mcfl_pkg::OP_READ, 0, 0, 0, 0));
        c = make_cmd(mcfl_pkg::OP_APPEND, mcfl_pkg::FEEDERS - 1, mcfl_pkg::PHASES - 1,
                     1, 14);
        c.stamp    = '1;
        c.current  = '1;
        c.duration = '1;
        c.below    = 1'b1;
        c.power    = 1'b1;
        command_queue.push_back(c);
        command_queue.push_back(make_cmd(mcfl_pkg::OP_READ, mcfl_pkg::FEEDERS - 1,
                                         mcfl_pkg::PHASES - 1, 1, 0));
        command_queue.push_back(make_cmd(mcfl_pkg::OP_READ, mcfl_pkg::FEEDERS - 1,
                                         mcfl_pkg::PHASES - 1, 1, 1));
        // one more than the ring holds, so the oldest is overwritten
        for (int i = 0; i <= mcfl_pkg::DEPTH; i++)
        begin
            c = make_cmd(mcfl_pkg::OP_APPEND, 3, 2, 0, 0);
            if (i > 0)
            begin
                c.stamp    = (mcfl_pkg::STAMP_W'(i) << 40) | mcfl_pkg::STAMP_W'(i);
                c.current  = mcfl_pkg::CUR_W'(i * 1000);
                c.duration = mcfl_pkg::DUR_W'(i * 37);
                c.below    = i[0];
                c.power    = i[1];
            end
            command_queue.push_back(c);
        end
        command_queue.push_back(make_cmd(mcfl_pkg::OP_READ, 3, 2, 0, mcfl_pkg::DEPTH - 1));
        command_queue.push_back(make_cmd(mcfl_pkg::OP_QUERY, 3, 2, 0, 0));
        command_queue.push_back(make_cmd(mcfl_pkg::OP_CLEAR, 0, 0, 0, 0));
        command_queue.push_back(make_cmd(mcfl_pkg::OP_READ, mcfl_pkg::FEEDERS - 1,
                                         mcfl_pkg::PHASES - 1, 1, 0));

        // Random phases, each centered on two rings so they fill and wrap
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            quiet = (ph == BURST_PHASE) || ($urandom_range(0, 2) == 0);
            if (ph == BURST_PHASE)
                burst_at = command_queue.size() + 10;
            hot0 = $urandom_range(0, mcfl_pkg::CHANNELS - 1);
            hot1 = $urandom_range(0, mcfl_pkg::CHANNELS - 1);
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                if ($urandom_range(0, 4) != 0)
                    ch = $urandom_range(0, 1) ? hot0 : hot1;
                else
                    ch = $urandom_range(0, mcfl_pkg::CHANNELS - 1);
                c = make_cmd(mcfl_pkg::OP_QUERY, ch / (mcfl_pkg::PHASES * 2),
                             (ch / 2) % mcfl_pkg::PHASES, ch % 2,
                             $urandom_range(0, 14));
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    c.op = mcfl_pkg::OP_APPEND;
                    gen_total[ch]++;
                end
                else if (pick < 80)
                begin
                    c.op = mcfl_pkg::OP_READ;
                    fill = (gen_total[ch] > mcfl_pkg::DEPTH) ? mcfl_pkg::DEPTH :
                           gen_total[ch];
                    if (fill > 0 && $urandom_range(0, 3) != 0)
                        c.nth = mcfl_pkg::NTH_W'($urandom_range(0, fill - 1));
                end
                else if (pick < 98)
                begin
                    c.op = mcfl_pkg::OP_QUERY;
                end
                else
                begin
                    c.op = mcfl_pkg::OP_CLEAR;
                    for (int i = 0; i < mcfl_pkg::CHANNELS; i++)
                        gen_total[i] = 0;
                end
                c.stamp    = mcfl_pkg::STAMP_W'({$urandom, $urandom});
                c.current  = mcfl_pkg::CUR_W'($urandom_range(0, 65535));
                c.duration = mcfl_pkg::DUR_W'($urandom_range(0, 65535));
                c.below    = 1'($urandom_range(0, 1));
                c.power    = 1'($urandom_range(0, 1));
                c.gap      = quiet ? 0 : idle_len();
                c.drain    = (k == 0) && (ph != BURST_PHASE);
                command_queue.push_back(c);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/mcfl_pkg.sv
rtl/core/mcfl_ram.sv
rtl/core/mcfl_front.sv
rtl/core/mcfl_back.sv
rtl/core/multichannel_circular_fault_log.sv
sim/tb_top.sv
